### sv/stt_pkg.sv
// Shared types and codes for the sparse triplet table.
package stt_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_RANGE     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ZERO      = 3'd4
	} status_t;

	// Width and reset of the dimension registers
	localparam int unsigned DIM_W = 11;
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

	// Register indexes, taken from paddr[2]
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	localparam int unsigned DATA_W = 32;

	// Update command broadcast to every cell
	typedef struct packed {
		logic ins;  // open a slot at the insert point and shift the tail up
		logic del;  // close the gap at the hit and shift the tail down
		logic ovw;  // overwrite the value of the matching cell
	} cell_cmd_t;

endpackage

### sv/stt_cell.sv
// One table cell: holds an entry, compares it with the request and shifts with its neighbours.
module stt_cell #(
	parameter int unsigned IDX_W = 10
) (
	input  logic                         clk,
	input  stt_pkg::cell_cmd_t           cmd,
	input  logic                         live,
	input  logic                         at_end,
	input  logic [IDX_W-1:0]             req_row,
	input  logic [IDX_W-1:0]             req_col,
	input  logic signed [stt_pkg::DATA_W-1:0] req_value,
	input  logic                         prev_tail,
	input  logic [IDX_W-1:0]             prev_row,
	input  logic [IDX_W-1:0]             prev_col,
	input  logic signed [stt_pkg::DATA_W-1:0] prev_value,
	input  logic [IDX_W-1:0]             next_row,
	input  logic [IDX_W-1:0]             next_col,
	input  logic signed [stt_pkg::DATA_W-1:0] next_value,
	output logic                         tail,
	output logic                         eq,
	output logic [IDX_W-1:0]             row,
	output logic [IDX_W-1:0]             col,
	output logic signed [stt_pkg::DATA_W-1:0] value
);
	import stt_pkg::*;

	logic [IDX_W-1:0]        row_q;
	logic [IDX_W-1:0]        col_q;
	logic signed [DATA_W-1:0] value_q;
	logic [2*IDX_W-1:0]      own_key;
	logic [2*IDX_W-1:0]      req_key;
	logic                    gt;
	logic                    ge;

	// Row-major order is plain unsigned order of the concatenated key
	assign own_key = {row_q, col_q};
	assign req_key = {req_row, req_col};
	assign eq      = live && (own_key == req_key);
	assign gt      = live && (own_key > req_key);
	assign ge      = eq || gt;
	// Cell at or beyond the insert point
	assign tail    = gt || at_end;

	assign row   = row_q;
	assign col   = col_q;
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_tail) begin
				row_q   <= prev_row;
				col_q   <= prev_col;
				value_q <= prev_value;
			end else if (tail) begin
				row_q   <= req_row;
				col_q   <= req_col;
				value_q <= req_value;
			end
		end else if (cmd.del) begin
			if (ge) begin
				row_q   <= next_row;
				col_q   <= next_col;
				value_q <= next_value;
			end
		end else if (cmd.ovw && eq) begin
			value_q <= req_value;
		end
	end

endmodule

### sv/sparse_triplet_table_unit.sv
// Top level: request register, cell chain, result register and configuration port.
//
//  channel   direction  handshake            payload
//  in        into       in_valid / in_stall  opcode, row, col, value
//  out       out of     out_valid/out_stall  read_value, found, status, entry_count
//  config    into       APB write/read       row_count (0x0), column_count (0x4)
//
// A request is registered at acceptance and executed once the result register is free,
// when every cell compares its key and the chain shifts in one step; the result is
// registered at the end of that execute cycle. A new request is taken in the execute
// cycle, so items stream at one per cycle while out_stall stays low. Reset
// empties the table by clearing the entry count and sets both dimensions to 1024;
// no clearing pass. A stalled result holds the execute cycle and with it the input side.
module sparse_triplet_table_unit #(
	parameter int unsigned CAPACITY   = 64,
	parameter int unsigned INDEX_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic [INDEX_BITS-1:0]             row,
	input  logic [INDEX_BITS-1:0]             col,
	input  logic signed [stt_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [stt_pkg::DATA_W-1:0] read_value,
	output logic                              found,
	output logic [2:0]                        status,
	output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [stt_pkg::DATA_W-1:0]        pwdata,
	output logic [stt_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import stt_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (INDEX_BITS + 1 > DIM_W) ? INDEX_BITS + 1 : DIM_W;

	// Configuration
	logic [DIM_W-1:0] row_count_q;
	logic [DIM_W-1:0] column_count_q;
	logic             cfg_wr;

	// Request stage
	logic                     busy_q;
	opcode_t                  op_s1;
	logic [INDEX_BITS-1:0]    row_s1;
	logic [INDEX_BITS-1:0]    col_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic                     exec;
	logic                     accept;

	// Table state
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	// Result register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic                     found_q;
	status_t                  status_q;
	logic [CNT_W-1:0]         entry_count_q;

	// Chain wiring
	logic [INDEX_BITS-1:0]    row_w   [CAPACITY];
	logic [INDEX_BITS-1:0]    col_w   [CAPACITY];
	logic signed [DATA_W-1:0] value_w [CAPACITY];
	logic [CAPACITY-1:0]      tail_w;
	logic [CAPACITY-1:0]      eq_w;

	cell_cmd_t                cmd;
	logic                     hit;
	logic signed [DATA_W-1:0] hit_value;
	logic                     in_range;
	logic                     full;
	logic signed [DATA_W-1:0] rd_d;
	status_t                  st_d;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= DIM_RESET;
			column_count_q <= DIM_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ROW_COUNT:    row_count_q    <= pwdata[DIM_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= pwdata[DIM_W-1:0];
				default:          row_count_q    <= row_count_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROW_COUNT:    prdata = DATA_W'(row_count_q);
			REG_COLUMN_COUNT: prdata = DATA_W'(column_count_q);
			default:          prdata = '0;
		endcase
	end

	// Handshake: execute once the result register is free
	assign exec     = busy_q && (!out_valid_q || !out_stall);
	assign in_stall = busy_q && !exec;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode_t'(opcode);
			row_s1   <= row;
			col_s1   <= col;
			value_s1 <= value;
		end
	end

	// Cell chain
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic                     prev_tail;
		logic [INDEX_BITS-1:0]    prev_row;
		logic [INDEX_BITS-1:0]    prev_col;
		logic signed [DATA_W-1:0] prev_value;
		logic [INDEX_BITS-1:0]    next_row;
		logic [INDEX_BITS-1:0]    next_col;
		logic signed [DATA_W-1:0] next_value;

		if (k == 0) begin : g_first
			assign prev_tail  = 1'b0;
			assign prev_row   = '0;
			assign prev_col   = '0;
			assign prev_value = '0;
		end else begin : g_mid
			assign prev_tail  = tail_w[k-1];
			assign prev_row   = row_w[k-1];
			assign prev_col   = col_w[k-1];
			assign prev_value = value_w[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign next_row   = row_w[k];
			assign next_col   = col_w[k];
			assign next_value = value_w[k];
		end else begin : g_inner
			assign next_row   = row_w[k+1];
			assign next_col   = col_w[k+1];
			assign next_value = value_w[k+1];
		end

		stt_cell #(
			.IDX_W(INDEX_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.live       (CNT_W'(k) < count_q),
			.at_end     (CNT_W'(k) == count_q),
			.req_row    (row_s1),
			.req_col    (col_s1),
			.req_value  (value_s1),
			.prev_tail  (prev_tail),
			.prev_row   (prev_row),
			.prev_col   (prev_col),
			.prev_value (prev_value),
			.next_row   (next_row),
			.next_col   (next_col),
			.next_value (next_value),
			.tail       (tail_w[k]),
			.eq         (eq_w[k]),
			.row        (row_w[k]),
			.col        (col_w[k]),
			.value      (value_w[k])
		);
	end

	// Keys are unique, so at most one cell matches
	always_comb begin
		hit_value = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (eq_w[k]) begin
				hit_value = hit_value | value_w[k];
			end
		end
	end

	assign hit      = |eq_w;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign in_range = (CMP_W'(row_s1) < CMP_W'(row_count_q)) &&
	                  (CMP_W'(col_s1) < CMP_W'(column_count_q));

	always_comb begin
		cmd     = '0;
		st_d    = ST_OK;
		rd_d    = '0;
		count_d = count_q;
		case (op_s1)
			OP_INSERT: begin
				if (full) begin
					st_d = ST_FULL;
				end else if (!in_range) begin
					st_d = ST_RANGE;
				end else if (value_s1 == '0) begin
					st_d = ST_ZERO;
				end else if (hit) begin
					cmd.ovw = exec;
				end else begin
					cmd.ins = exec;
					count_d = count_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (!in_range) begin
					st_d = ST_RANGE;
				end else if (!hit) begin
					st_d = ST_NOT_FOUND;
				end else begin
					cmd.del = exec;
					count_d = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (!in_range) begin
					st_d = ST_RANGE;
				end else if (hit) begin
					rd_d = hit_value;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			read_value_q  <= rd_d;
			found_q       <= hit;
			status_q      <= st_d;
			entry_count_q <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign found       = found_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule
